// ----- src/pidaw_pkg.sv -----
// Shared types, constants and saturation helpers for the PID controller with
// back-calculation anti-windup. No dependencies; every other file imports it.
package pidaw_pkg;

  localparam int DATA_W  = 32;  // signal, gain and limit width (Q16.16)
  localparam int INTEG_W = 48;  // integral accumulator width (Q32.16)
  localparam int STEP_W  = 16;  // control period width (Q0.16)
  localparam int FRAC_W  = 16;  // fraction bits dropped after a product
  localparam int OP_W    = 33;  // shared multiplier operand width
  localparam int PROD_W  = 2 * OP_W;
  localparam int SUM_W   = 64;  // drive accumulator width
  localparam int UPD_W   = 52;  // integral update sum width
  localparam int IDX_W   = 3;   // configuration index width

  // Configuration register indexes
  typedef enum logic [IDX_W-1:0] {
    REG_PROP_GAIN   = 3'd0,
    REG_DERIV_GAIN  = 3'd1,
    REG_INTEG_GAIN  = 3'd2,
    REG_WINDUP_GAIN = 3'd3,
    REG_DRIVE_LOW   = 3'd4,
    REG_DRIVE_HIGH  = 3'd5,
    REG_STEP_TIME   = 3'd6,
    REG_BYPASS_MODE = 3'd7
  } reg_index_t;

  typedef struct packed {
    logic signed [DATA_W-1:0] prop_gain;
    logic signed [DATA_W-1:0] deriv_gain;
    logic signed [DATA_W-1:0] integ_gain;
    logic signed [DATA_W-1:0] windup_gain;
    logic signed [DATA_W-1:0] drive_low;
    logic signed [DATA_W-1:0] drive_high;
    logic [STEP_W-1:0]        step_time;
    logic                     bypass_mode;
  } cfg_t;

  // Operand pair for the shared multiplier
  typedef enum logic [2:0] {
    MUL_P    = 3'd0,
    MUL_D    = 3'd1,
    MUL_IHI  = 3'd2,
    MUL_ILO  = 3'd3,
    MUL_EDT  = 3'd4,
    MUL_WIND = 3'd5
  } mul_sel_t;

  // How the last product folds into the drive accumulator
  typedef enum logic [1:0] {
    ADD_HOLD  = 2'd0,
    ADD_SHIFT = 2'd1,
    ADD_FULL  = 2'd2
  } add_sel_t;

  typedef struct packed {
    logic     load;
    logic     mul_en;
    mul_sel_t mul_sel;
    add_sel_t add_sel;
    logic     clamp_en;
    logic     update_en;
    logic     out_load;
  } dp_cmd_t;

  typedef struct packed {
    logic out_free;
  } dp_sts_t;

  localparam logic signed [DATA_W-1:0] DATA_MAX = {1'b0, {(DATA_W-1){1'b1}}};
  localparam logic signed [DATA_W-1:0] DATA_MIN = {1'b1, {(DATA_W-1){1'b0}}};
  localparam logic signed [INTEG_W-1:0] INTEG_MAX = {1'b0, {(INTEG_W-1){1'b1}}};
  localparam logic signed [INTEG_W-1:0] INTEG_MIN = {1'b1, {(INTEG_W-1){1'b0}}};

  // Saturate a one-bit-grown difference to the signal width
  function automatic logic signed [DATA_W-1:0] sat_diff(input logic signed [DATA_W:0] x);
    logic signed [DATA_W-1:0] r;
    if (x[DATA_W] != x[DATA_W-1]) begin
      r = x[DATA_W] ? DATA_MIN : DATA_MAX;
    end else begin
      r = x[DATA_W-1:0];
    end
    return r;
  endfunction

  // Saturate the drive sum to the signal width
  function automatic logic signed [DATA_W-1:0] sat_sum(input logic signed [SUM_W-1:0] x);
    logic signed [SUM_W-1:0] hi;
    logic signed [SUM_W-1:0] lo;
    logic signed [DATA_W-1:0] r;
    hi = {{(SUM_W-DATA_W){1'b0}}, DATA_MAX};
    lo = {{(SUM_W-DATA_W){1'b1}}, DATA_MIN};
    if (x > hi) begin
      r = DATA_MAX;
    end else if (x < lo) begin
      r = DATA_MIN;
    end else begin
      r = x[DATA_W-1:0];
    end
    return r;
  endfunction

  // Saturate the integral update to the accumulator width
  function automatic logic signed [INTEG_W-1:0] sat_integ(input logic signed [UPD_W-1:0] x);
    logic signed [UPD_W-1:0] hi;
    logic signed [UPD_W-1:0] lo;
    logic signed [INTEG_W-1:0] r;
    hi = {{(UPD_W-INTEG_W){1'b0}}, INTEG_MAX};
    lo = {{(UPD_W-INTEG_W){1'b1}}, INTEG_MIN};
    if (x > hi) begin
      r = INTEG_MAX;
    end else if (x < lo) begin
      r = INTEG_MIN;
    end else begin
      r = x[INTEG_W-1:0];
    end
    return r;
  endfunction

endpackage

// ----- src/pidaw_cfg.sv -----
// Configuration register file for the PID controller.
// Depends on pidaw_pkg for the register index codes and cfg_t.
module pidaw_cfg (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                cfg_valid,
  output logic                                cfg_ready,
  input  logic [pidaw_pkg::IDX_W-1:0]         cfg_index,
  input  logic [pidaw_pkg::DATA_W-1:0]        cfg_data,
  output pidaw_pkg::cfg_t                     cfg
);
  import pidaw_pkg::*;

  // Take a write word every cycle
  assign cfg_ready = 1'b1;

  // Write the addressed register
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.prop_gain   <= '0;
      cfg.deriv_gain  <= '0;
      cfg.integ_gain  <= '0;
      cfg.windup_gain <= '0;
      cfg.drive_low   <= DATA_MIN;
      cfg.drive_high  <= DATA_MAX;
      cfg.step_time   <= STEP_W'(66);
      cfg.bypass_mode <= 1'b0;
    end else if (cfg_valid && cfg_ready) begin
      case (reg_index_t'(cfg_index))
        REG_PROP_GAIN:   cfg.prop_gain   <= cfg_data;
        REG_DERIV_GAIN:  cfg.deriv_gain  <= cfg_data;
        REG_INTEG_GAIN:  cfg.integ_gain  <= cfg_data;
        REG_WINDUP_GAIN: cfg.windup_gain <= cfg_data;
        REG_DRIVE_LOW:   cfg.drive_low   <= cfg_data;
        REG_DRIVE_HIGH:  cfg.drive_high  <= cfg_data;
        REG_STEP_TIME:   cfg.step_time   <= cfg_data[STEP_W-1:0];
        REG_BYPASS_MODE: cfg.bypass_mode <= cfg_data[0];
        default: ;
      endcase
    end
  end

endmodule

// ----- src/pidaw_ctrl.sv -----
// Sequencer for the PID datapath: walks one sample through the shared
// multiplier, clamp and integral update. Depends on pidaw_pkg.
module pidaw_ctrl (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic               bypass_mode,
  input  pidaw_pkg::dp_sts_t sts,
  output pidaw_pkg::dp_cmd_t cmd
);
  import pidaw_pkg::*;

  typedef enum logic [9:0] {
    S_IDLE  = 10'b00_0000_0001,
    S_P     = 10'b00_0000_0010,
    S_D     = 10'b00_0000_0100,
    S_IHI   = 10'b00_0000_1000,
    S_ILO   = 10'b00_0001_0000,
    S_EDT   = 10'b00_0010_0000,
    S_CLAMP = 10'b00_0100_0000,
    S_WIND  = 10'b00_1000_0000,
    S_UPD   = 10'b01_0000_0000,
    S_OUT   = 10'b10_0000_0000
  } state_t;

  state_t state;
  state_t state_next;

  // Advance the state
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Issue datapath commands per step
  always_comb begin
    state_next  = state;
    in_ready    = 1'b0;
    cmd         = '0;
    cmd.mul_sel = MUL_P;
    cmd.add_sel = ADD_HOLD;
    case (state)
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.load   = 1'b1;
          state_next = bypass_mode ? S_OUT : S_P;
        end
      end
      S_P: begin
        cmd.mul_en  = 1'b1;
        cmd.mul_sel = MUL_P;
        state_next  = S_D;
      end
      S_D: begin
        cmd.mul_en  = 1'b1;
        cmd.mul_sel = MUL_D;
        cmd.add_sel = ADD_SHIFT;
        state_next  = S_IHI;
      end
      S_IHI: begin
        cmd.mul_en  = 1'b1;
        cmd.mul_sel = MUL_IHI;
        cmd.add_sel = ADD_SHIFT;
        state_next  = S_ILO;
      end
      S_ILO: begin
        cmd.mul_en  = 1'b1;
        cmd.mul_sel = MUL_ILO;
        cmd.add_sel = ADD_FULL;
        state_next  = S_EDT;
      end
      S_EDT: begin
        cmd.mul_en  = 1'b1;
        cmd.mul_sel = MUL_EDT;
        cmd.add_sel = ADD_SHIFT;
        state_next  = S_CLAMP;
      end
      S_CLAMP: begin
        cmd.clamp_en = 1'b1;
        state_next   = S_WIND;
      end
      S_WIND: begin
        cmd.mul_en  = 1'b1;
        cmd.mul_sel = MUL_WIND;
        state_next  = S_UPD;
      end
      S_UPD: begin
        cmd.update_en = 1'b1;
        state_next    = S_OUT;
      end
      S_OUT: begin
        // Hold the result until the output register is free
        if (sts.out_free) begin
          cmd.out_load = 1'b1;
          state_next   = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

`ifndef SYNTHESIS
  a_out_load_free: assert property (@(posedge clk) disable iff (rst)
    cmd.out_load |-> sts.out_free)
    else $error("result word loaded while output register still full");
`endif

endmodule

// ----- src/pidaw_dp.sv -----
// Datapath of the PID controller: error forming, shared 33x33 multiplier,
// drive accumulator, clamp, integral state and output register. Uses pidaw_pkg.
module pidaw_dp (
  input  logic                               clk,
  input  logic                               rst,
  input  pidaw_pkg::dp_cmd_t                 cmd,
  output pidaw_pkg::dp_sts_t                 sts,
  input  pidaw_pkg::cfg_t                    cfg,
  input  logic signed [pidaw_pkg::DATA_W-1:0] target,
  input  logic signed [pidaw_pkg::DATA_W-1:0] target_rate,
  input  logic signed [pidaw_pkg::DATA_W-1:0] feedforward,
  input  logic signed [pidaw_pkg::DATA_W-1:0] measured,
  input  logic signed [pidaw_pkg::DATA_W-1:0] measured_rate,
  input  logic                               clear,
  output logic                               out_valid,
  input  logic                               out_ready,
  output logic signed [pidaw_pkg::DATA_W-1:0] drive,
  output logic signed [pidaw_pkg::DATA_W-1:0] current_error
);
  import pidaw_pkg::*;

  // Controller state
  logic signed [INTEG_W-1:0] integ;
  logic signed [DATA_W-1:0]  last_err;

  // Working registers
  logic signed [DATA_W-1:0] rate_err;
  logic signed [SUM_W-1:0]  acc;
  logic signed [PROD_W-1:0] prod;
  logic signed [DATA_W-1:0] drive_r;
  logic signed [DATA_W-1:0] edt;
  logic signed [DATA_W:0]   diff;

  // Combinational values
  logic signed [DATA_W-1:0]  err_next;
  logic signed [DATA_W-1:0]  rerr_next;
  logic signed [OP_W-1:0]    op_a;
  logic signed [OP_W-1:0]    op_b;
  logic signed [PROD_W-1:0]  prod_sh;
  logic signed [DATA_W-1:0]  uncl;
  logic signed [DATA_W-1:0]  clamped;
  logic signed [DATA_W:0]    diff_next;
  logic signed [UPD_W-1:0]   ext_integ;
  logic signed [UPD_W-1:0]   ext_edt;
  logic signed [UPD_W-1:0]   wterm;
  logic signed [UPD_W-1:0]   upd;

  // Form tracking and rate errors
  assign err_next  = sat_diff({target[DATA_W-1], target} - {measured[DATA_W-1], measured});
  assign rerr_next = sat_diff({target_rate[DATA_W-1], target_rate}
                              - {measured_rate[DATA_W-1], measured_rate});

  // Select multiplier operands; the integral term is split into high and low halves
  always_comb begin
    op_a = {cfg.prop_gain[DATA_W-1], cfg.prop_gain};
    op_b = {last_err[DATA_W-1], last_err};
    case (cmd.mul_sel)
      MUL_P: begin
        op_a = {cfg.prop_gain[DATA_W-1], cfg.prop_gain};
        op_b = {last_err[DATA_W-1], last_err};
      end
      MUL_D: begin
        op_a = {cfg.deriv_gain[DATA_W-1], cfg.deriv_gain};
        op_b = {rate_err[DATA_W-1], rate_err};
      end
      MUL_IHI: begin
        op_a = {cfg.integ_gain[DATA_W-1], cfg.integ_gain};
        op_b = {integ[INTEG_W-1], integ[INTEG_W-1:FRAC_W]};
      end
      MUL_ILO: begin
        op_a = {cfg.integ_gain[DATA_W-1], cfg.integ_gain};
        op_b = {{(OP_W-FRAC_W){1'b0}}, integ[FRAC_W-1:0]};
      end
      MUL_EDT: begin
        op_a = {last_err[DATA_W-1], last_err};
        op_b = {{(OP_W-STEP_W){1'b0}}, cfg.step_time};
      end
      MUL_WIND: begin
        op_a = {cfg.windup_gain[DATA_W-1], cfg.windup_gain};
        op_b = diff;
      end
      default: ;
    endcase
  end

  // Floor of product over 2^16
  assign prod_sh = prod >>> FRAC_W;

  // Saturate and clamp the drive; low limit first, then high
  always_comb begin
    uncl    = sat_sum(acc);
    clamped = uncl;
    if (clamped < cfg.drive_low) begin
      clamped = cfg.drive_low;
    end
    if (clamped > cfg.drive_high) begin
      clamped = cfg.drive_high;
    end
    diff_next = {uncl[DATA_W-1], uncl} - {clamped[DATA_W-1], clamped};
  end

  // Integral update with back-calculation
  assign ext_integ = {{(UPD_W-INTEG_W){integ[INTEG_W-1]}}, integ};
  assign ext_edt   = {{(UPD_W-DATA_W){edt[DATA_W-1]}}, edt};
  assign wterm     = prod_sh[UPD_W-1:0];
  assign upd       = ext_integ + ext_edt - wterm;

  // Hold state; clear and error capture happen as the word is taken
  always_ff @(posedge clk) begin
    if (rst) begin
      integ     <= '0;
      last_err  <= '0;
      out_valid <= 1'b0;
    end else begin
      if (cmd.load) begin
        if (clear) begin
          integ    <= '0;
          last_err <= '0;
        end
        if (!cfg.bypass_mode) begin
          last_err <= err_next;
        end
      end
      if (cmd.update_en) begin
        integ <= sat_integ(upd);
      end
      if (cmd.out_load) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  // Working and output payload registers
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      rate_err <= rerr_next;
      acc      <= {{(SUM_W-DATA_W){feedforward[DATA_W-1]}}, feedforward};
      drive_r  <= target;
    end
    if (cmd.mul_en) begin
      prod <= op_a * op_b;
    end
    case (cmd.add_sel)
      ADD_SHIFT: acc <= acc + prod_sh[SUM_W-1:0];
      ADD_FULL:  acc <= acc + prod[SUM_W-1:0];
      default: ;
    endcase
    if (cmd.clamp_en) begin
      drive_r <= clamped;
      diff    <= diff_next;
      edt     <= prod_sh[DATA_W-1:0];
    end
    if (cmd.out_load) begin
      drive         <= drive_r;
      current_error <= last_err;
    end
  end

  assign sts.out_free = !out_valid || out_ready;

`ifndef SYNTHESIS
  a_clamp_range: assert property (@(posedge clk) disable iff (rst)
    cmd.clamp_en && (cfg.drive_low <= cfg.drive_high)
    |=> (drive_r >= $past(cfg.drive_low)) && (drive_r <= $past(cfg.drive_high)))
    else $error("clamped drive outside limits");
  a_clamp_inverted: assert property (@(posedge clk) disable iff (rst)
    cmd.clamp_en && (cfg.drive_low > cfg.drive_high)
    |=> drive_r == $past(cfg.drive_high))
    else $error("inverted limits must give the high limit");
`endif

endmodule

// ----- src/pid_antiwindup_controller_unit.sv -----
// Top level of the PID controller with back-calculation anti-windup.
// Instantiates pidaw_cfg, pidaw_ctrl and pidaw_dp; types from pidaw_pkg.
//
// channel | handshake             | payload
// --------+-----------------------+------------------------------------------------
// in      | in_valid / in_ready   | target, target_rate, feedforward, measured,
//         |                       | measured_rate, clear
// out     | out_valid / out_ready | drive, current_error
// cfg     | cfg_valid / cfg_ready | cfg_index, cfg_data
//
// A closed-loop word runs six passes through the one shared 33x33 multiplier,
// a clamp step and an integral update before the next accept; a bypass word
// goes straight to the output step. The result sits in an output register, so
// a new word is taken while it waits; only the final load of a later result
// stalls. Reset is synchronous: configuration registers return to their
// defaults, integral and error to zero. Configuration words are taken every cycle.
module pid_antiwindup_controller_unit (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                in_valid,
  output logic                                in_ready,
  input  logic signed [pidaw_pkg::DATA_W-1:0] target,
  input  logic signed [pidaw_pkg::DATA_W-1:0] target_rate,
  input  logic signed [pidaw_pkg::DATA_W-1:0] feedforward,
  input  logic signed [pidaw_pkg::DATA_W-1:0] measured,
  input  logic signed [pidaw_pkg::DATA_W-1:0] measured_rate,
  input  logic                                clear,
  output logic                                out_valid,
  input  logic                                out_ready,
  output logic signed [pidaw_pkg::DATA_W-1:0] drive,
  output logic signed [pidaw_pkg::DATA_W-1:0] current_error,
  input  logic                                cfg_valid,
  output logic                                cfg_ready,
  input  logic [pidaw_pkg::IDX_W-1:0]         cfg_index,
  input  logic [pidaw_pkg::DATA_W-1:0]        cfg_data
);
  import pidaw_pkg::*;

  cfg_t    cfg;
  dp_cmd_t cmd;
  dp_sts_t sts;

  // Register file
  pidaw_cfg u_cfg (
    .clk       (clk),
    .rst       (rst),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg)
  );

  // Sequencer
  pidaw_ctrl u_ctrl (
    .clk         (clk),
    .rst         (rst),
    .in_valid    (in_valid),
    .in_ready    (in_ready),
    .bypass_mode (cfg.bypass_mode),
    .sts         (sts),
    .cmd         (cmd)
  );

  // Arithmetic and state
  pidaw_dp u_dp (
    .clk           (clk),
    .rst           (rst),
    .cmd           (cmd),
    .sts           (sts),
    .cfg           (cfg),
    .target        (target),
    .target_rate   (target_rate),
    .feedforward   (feedforward),
    .measured      (measured),
    .measured_rate (measured_rate),
    .clear         (clear),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .drive         (drive),
    .current_error (current_error)
  );

`ifndef SYNTHESIS
  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready |=> !in_ready)
    else $error("input word taken while previous word still in work");
`endif

endmodule

// ----- test/tb_pid_antiwindup_controller_unit.sv -----
// Self-checking bench for the PID controller with back-calculation anti-windup.
// Drives sample words and register writes into pid_antiwindup_controller_unit and
// checks every result word against an in-bench predictor; types from pidaw_pkg.
module tb_pid_antiwindup_controller_unit;
  import pidaw_pkg::*;

  localparam int CYCLE_LIMIT = 200000;  // hard stop for a hung run
  localparam int SETTLE      = 12;      // idle cycles required before a register write
  localparam int TAIL        = 30;      // cycles watched after the last result
  localparam int PHASES      = 8;       // random register settings
  localparam int PHASE_WORDS = 56;      // sample words per random setting

  typedef logic signed [95:0] wide_t;

  typedef enum logic [1:0] {
    ACT_SAMPLE,
    ACT_WRITE,
    ACT_DRAIN
  } stim_kind_t;

  typedef struct {
    logic signed [DATA_W-1:0] target;
    logic signed [DATA_W-1:0] target_rate;
    logic signed [DATA_W-1:0] feedforward;
    logic signed [DATA_W-1:0] measured;
    logic signed [DATA_W-1:0] measured_rate;
    logic                     clear;
  } ctl_sample_t;

  typedef struct {
    stim_kind_t       kind;
    ctl_sample_t      smp;
    reg_index_t       idx;
    logic [DATA_W-1:0] data;
  } stim_t;

  typedef struct packed {
    logic signed [DATA_W-1:0] drive;
    logic signed [DATA_W-1:0] current_error;
  } drive_word_t;

  logic clk = 1'b0;
  logic rst = 1'b1;

  logic                     in_valid = 1'b0;
  logic                     in_ready;
  logic signed [DATA_W-1:0] target = '0;
  logic signed [DATA_W-1:0] target_rate = '0;
  logic signed [DATA_W-1:0] feedforward = '0;
  logic signed [DATA_W-1:0] measured = '0;
  logic signed [DATA_W-1:0] measured_rate = '0;
  logic                     clear = 1'b0;
  logic                     out_valid;
  logic                     out_ready = 1'b0;
  logic signed [DATA_W-1:0] drive;
  logic signed [DATA_W-1:0] current_error;
  logic                     cfg_valid = 1'b0;
  logic                     cfg_ready;
  logic [IDX_W-1:0]         cfg_index = '0;
  logic [DATA_W-1:0]        cfg_data = '0;

  // Predictor copy of the registers and the loop state
  cfg_t                      model_cfg;
  logic signed [INTEG_W-1:0] integ_acc;
  logic signed [DATA_W-1:0]  last_err;

  stim_t       pending_q[$];
  drive_word_t drive_expect_q[$];
  stim_t       cur_stim;

  int burst_left = 0;
  int gap_left = 0;
  int quiet_cycles = 0;
  int rdy_left = 0;
  int rdy_mode = 0;
  int cycle_cnt = 0;

  int samples_sent = 0;
  int bypass_sent = 0;
  int clears_sent = 0;
  int clamp_hits = 0;
  int writes_done = 0;
  int results_checked = 0;
  int mismatch_cnt = 0;

  pid_antiwindup_controller_unit dut (
    .clk          (clk),
    .rst          (rst),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .target       (target),
    .target_rate  (target_rate),
    .feedforward  (feedforward),
    .measured     (measured),
    .measured_rate(measured_rate),
    .clear        (clear),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .drive        (drive),
    .current_error(current_error),
    .cfg_valid    (cfg_valid),
    .cfg_ready    (cfg_ready),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // Clip a wide value to a signed range of the given width
  function automatic wide_t sat_wide(input wide_t x, input int bits);
    wide_t hi;
    wide_t lo;
    hi = (wide_t'(1) <<< (bits - 1)) - 1;
    lo = -hi - 1;
    if (x > hi) begin
      return hi;
    end
    if (x < lo) begin
      return lo;
    end
    return x;
  endfunction

  // Work out one result word and advance the predicted loop state
  function automatic drive_word_t compute_drive(input ctl_sample_t s);
    drive_word_t r;
    wide_t err, rerr, sum, unc, drv, lo, hi, acc, stp, edt, wterm, upd;
    if (s.clear) begin
      integ_acc = '0;
      last_err  = '0;
    end
    if (model_cfg.bypass_mode) begin
      bypass_sent++;
      r.drive         = s.target;
      r.current_error = last_err;
      return r;
    end
    err  = sat_wide(wide_t'($signed(s.target)) - wide_t'($signed(s.measured)), DATA_W);
    rerr = sat_wide(wide_t'($signed(s.target_rate)) - wide_t'($signed(s.measured_rate)),
                    DATA_W);
    acc  = wide_t'($signed(integ_acc));
    // Exact sum of the terms, each product floored after the fraction shift
    sum = wide_t'($signed(s.feedforward));
    sum = sum + ((wide_t'($signed(model_cfg.prop_gain)) * err) >>> FRAC_W);
    sum = sum + ((wide_t'($signed(model_cfg.deriv_gain)) * rerr) >>> FRAC_W);
    sum = sum + ((wide_t'($signed(model_cfg.integ_gain)) * acc) >>> FRAC_W);
    unc = sat_wide(sum, DATA_W);
    // Raise to the low limit first, then lower to the high limit
    lo  = wide_t'($signed(model_cfg.drive_low));
    hi  = wide_t'($signed(model_cfg.drive_high));
    drv = unc;
    if (drv < lo) begin
      drv = lo;
    end
    if (drv > hi) begin
      drv = hi;
    end
    if (drv != unc) begin
      clamp_hits++;
    end
    // Integrate error and bleed off the clamped excess
    stp   = $signed({80'b0, model_cfg.step_time});
    edt   = (err * stp) >>> FRAC_W;
    wterm = (wide_t'($signed(model_cfg.windup_gain)) * (unc - drv)) >>> FRAC_W;
    upd   = sat_wide(acc + edt - wterm, INTEG_W);
    integ_acc = upd[INTEG_W-1:0];
    last_err  = err[DATA_W-1:0];
    r.drive         = drv[DATA_W-1:0];
    r.current_error = err[DATA_W-1:0];
    return r;
  endfunction

  function automatic void add_sample(input logic [DATA_W-1:0] t, input logic [DATA_W-1:0] tr,
                                     input logic [DATA_W-1:0] ff, input logic [DATA_W-1:0] m,
                                     input logic [DATA_W-1:0] mr, input logic c);
    stim_t st;
    st.kind              = ACT_SAMPLE;
    st.smp.target        = t;
    st.smp.target_rate   = tr;
    st.smp.feedforward   = ff;
    st.smp.measured      = m;
    st.smp.measured_rate = mr;
    st.smp.clear         = c;
    st.idx               = REG_PROP_GAIN;
    st.data              = '0;
    pending_q.push_back(st);
  endfunction

  function automatic void add_write(input reg_index_t idx, input logic [DATA_W-1:0] data);
    stim_t st;
    st.kind = ACT_WRITE;
    st.smp  = '{default: '0};
    st.idx  = idx;
    st.data = data;
    pending_q.push_back(st);
  endfunction

  function automatic int rand_small(input int span);
    return int'($urandom_range(0, 2 * span)) - span;
  endfunction

  // Full-range word with extra weight on the extremes and small values
  function automatic logic [DATA_W-1:0] rand_word();
    logic [DATA_W-1:0] r;
    case ($urandom_range(0, 7))
      0: r = DATA_MAX;
      1: r = DATA_MIN;
      2, 3, 4: r = rand_small(32'h0100_0000);
      default: r = $urandom();
    endcase
    return r;
  endfunction

  function automatic logic [DATA_W-1:0] rand_gain();
    logic [DATA_W-1:0] r;
    case ($urandom_range(0, 5))
      0: r = '0;
      1: r = DATA_MAX;
      2: r = DATA_MIN;
      3, 4: r = rand_small(32'h0004_0000);
      default: r = $urandom();
    endcase
    return r;
  endfunction

  // Driver: present sample words in bursts, register writes only when idle
  always @(posedge clk) begin
    stim_t head;
    logic  take_in;
    logic  take_cfg;
    logic  hold_in;
    logic  hold_cfg;
    if (rst) begin
      in_valid  <= 1'b0;
      cfg_valid <= 1'b0;
      model_cfg = '0;
      model_cfg.drive_low  = DATA_MIN;
      model_cfg.drive_high = DATA_MAX;
      model_cfg.step_time  = 16'd66;
      integ_acc    = '0;
      last_err     = '0;
      burst_left   = 0;
      gap_left     = 0;
      quiet_cycles = 0;
    end else begin
      take_in  = in_valid && in_ready;
      take_cfg = cfg_valid && cfg_ready;
      if (take_in) begin
        drive_expect_q.push_back(compute_drive(cur_stim.smp));
        samples_sent++;
        if (cur_stim.smp.clear) begin
          clears_sent++;
        end
      end
      if (take_cfg) begin
        writes_done++;
        case (cur_stim.idx)
          REG_PROP_GAIN:   model_cfg.prop_gain   = cur_stim.data;
          REG_DERIV_GAIN:  model_cfg.deriv_gain  = cur_stim.data;
          REG_INTEG_GAIN:  model_cfg.integ_gain  = cur_stim.data;
          REG_WINDUP_GAIN: model_cfg.windup_gain = cur_stim.data;
          REG_DRIVE_LOW:   model_cfg.drive_low   = cur_stim.data;
          REG_DRIVE_HIGH:  model_cfg.drive_high  = cur_stim.data;
          REG_STEP_TIME:   model_cfg.step_time   = cur_stim.data[STEP_W-1:0];
          REG_BYPASS_MODE: model_cfg.bypass_mode = cur_stim.data[0];
          default: ;
        endcase
      end
      hold_in  = in_valid && !take_in;
      hold_cfg = cfg_valid && !take_cfg;
      if (drive_expect_q.size() == 0 && !hold_in) begin
        quiet_cycles++;
      end else begin
        quiet_cycles = 0;
      end
      // Pick up the next pending word once both channels are free
      if (!hold_in && !hold_cfg && pending_q.size() > 0) begin
        head = pending_q[0];
        case (head.kind)
          ACT_SAMPLE: begin
            if (gap_left > 0) begin
              gap_left--;
            end else begin
              cur_stim = head;
              void'(pending_q.pop_front());
              hold_in = 1'b1;
              target        <= head.smp.target;
              target_rate   <= head.smp.target_rate;
              feedforward   <= head.smp.feedforward;
              measured      <= head.smp.measured;
              measured_rate <= head.smp.measured_rate;
              clear         <= head.smp.clear;
              if (burst_left > 0) begin
                burst_left--;
              end else begin
                burst_left = $urandom_range(1, 16);
                gap_left   = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
                if ($urandom_range(0, 9) == 0) begin
                  burst_left = 40;
                  gap_left   = 0;
                end
              end
            end
          end
          ACT_WRITE: begin
            if (quiet_cycles >= SETTLE) begin
              cur_stim = head;
              void'(pending_q.pop_front());
              hold_cfg = 1'b1;
              cfg_index <= head.idx;
              cfg_data  <= head.data;
            end
          end
          default: begin
            if (quiet_cycles >= SETTLE) begin
              void'(pending_q.pop_front());
            end
          end
        endcase
      end
      in_valid  <= hold_in;
      cfg_valid <= hold_cfg;
    end
  end

  // Receiver: switch between free flow, random and heavy stalls
  always @(posedge clk) begin
    logic nxt_ready;
    if (rst) begin
      out_ready <= 1'b0;
      rdy_left = 0;
      rdy_mode = 0;
    end else begin
      if (rdy_left == 0) begin
        rdy_mode = $urandom_range(0, 3);
        rdy_left = (rdy_mode == 3) ? $urandom_range(1, 16) : $urandom_range(4, 40);
      end else begin
        rdy_left--;
      end
      case (rdy_mode)
        0: nxt_ready = 1'b1;
        1: nxt_ready = ($urandom_range(0, 1) == 1);
        2: nxt_ready = ($urandom_range(0, 3) == 0);
        default: nxt_ready = 1'b0;
      endcase
      out_ready <= nxt_ready;
    end
  end

  // Monitor: compare each result word with the oldest prediction
  always @(posedge clk) begin
    drive_word_t want;
    if (!rst && out_valid && out_ready) begin
      if (drive_expect_q.size() == 0) begin
        mismatch_cnt++;
        if (mismatch_cnt <= 10) begin
          $display("unexpected result word: drive %h error %h", drive, current_error);
        end
      end else begin
        want = drive_expect_q.pop_front();
        results_checked++;
        if (drive !== want.drive || current_error !== want.current_error) begin
          mismatch_cnt++;
          if (mismatch_cnt <= 10) begin
            $display("mismatch on result %0d: drive exp %h got %h, error exp %h got %h",
                     results_checked, want.drive, drive, want.current_error, current_error);
          end
        end
      end
    end
  end

  // Stop a run that hangs
  initial begin
    cycle_cnt = 0;
    while (cycle_cnt < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_cnt++;
    end
    $display("timeout after %0d cycles, %0d results outstanding", cycle_cnt,
             drive_expect_q.size());
    $display("== FAIL ==");
    $finish;
  end

  initial begin
    stim_t             drain_mark;
    int                drain_at;
    int                lim;
    logic [DATA_W-1:0] lo_w;
    logic [DATA_W-1:0] t;
    drain_mark.kind = ACT_DRAIN;
    drain_mark.smp  = '{default: '0};
    drain_mark.idx  = REG_PROP_GAIN;
    drain_mark.data = '0;

    // Reset defaults: zero gains, full-range limits
    add_sample('0, '0, '0, '0, '0, 1'b0);
    add_sample(DATA_MAX, DATA_MAX, DATA_MAX, DATA_MIN, DATA_MIN, 1'b0);
    add_sample(DATA_MIN, DATA_MIN, DATA_MIN, DATA_MAX, DATA_MAX, 1'b0);

    // Moderate gains and limits of +/-100
    add_write(REG_PROP_GAIN, 32'h0001_0000);
    add_write(REG_DERIV_GAIN, 32'h0000_8000);
    add_write(REG_INTEG_GAIN, 32'h0000_4000);
    add_write(REG_WINDUP_GAIN, 32'h0001_0000);
    add_write(REG_DRIVE_LOW, 32'hFF9C_0000);
    add_write(REG_DRIVE_HIGH, 32'h0064_0000);
    add_write(REG_STEP_TIME, 32'h0000_8000);
    add_write(REG_BYPASS_MODE, 32'h0);
    add_sample(32'h0003_0000, '0, '0, 32'h0001_0000, '0, 1'b0);
    add_sample(32'h0003_0000, '0, '0, 32'h0001_0000, '0, 1'b0);
    add_sample('0, '0, 32'h00C8_0000, '0, '0, 1'b0);
    add_sample('0, '0, 32'hFF38_0000, '0, '0, 1'b0);
    add_sample(DATA_MAX, '0, DATA_MAX, DATA_MIN, '0, 1'b0);
    add_sample(32'h0001_0000, '0, '0, '0, '0, 1'b1);
    add_sample('0, 32'h0005_0000, '0, '0, 32'hFFFD_8000, 1'b0);

    // Inverted limits: the high limit wins
    add_write(REG_DRIVE_LOW, 32'h0032_0000);
    add_write(REG_DRIVE_HIGH, 32'hFFCE_0000);
    add_sample('0, '0, '0, '0, '0, 1'b0);
    add_sample('0, '0, 32'h03E8_0000, '0, '0, 1'b0);

    // Open loop: reference passes through, clear still zeroes the state
    add_write(REG_BYPASS_MODE, 32'h1);
    add_sample(32'h0007_8000, '0, '0, '0, '0, 1'b0);
    add_sample(DATA_MIN, '0, '0, '0, '0, 1'b1);
    add_sample(DATA_MAX, DATA_MIN, DATA_MAX, DATA_MIN, DATA_MAX, 1'b0);

    // Extreme gains with a zero-width clamp: the integral runs into saturation
    add_write(REG_PROP_GAIN, DATA_MAX);
    add_write(REG_DERIV_GAIN, DATA_MIN);
    add_write(REG_INTEG_GAIN, DATA_MAX);
    add_write(REG_WINDUP_GAIN, DATA_MIN);
    add_write(REG_DRIVE_LOW, '0);
    add_write(REG_DRIVE_HIGH, '0);
    add_write(REG_STEP_TIME, 32'h0000_FFFF);
    add_write(REG_BYPASS_MODE, 32'h0);
    repeat (4) begin
      add_sample(DATA_MAX, DATA_MAX, DATA_MAX, DATA_MIN, DATA_MIN, 1'b0);
    end
    add_sample(DATA_MIN, DATA_MIN, DATA_MIN, DATA_MAX, DATA_MAX, 1'b1);

    // Opposite extremes with a narrow clamp and no integration
    add_write(REG_PROP_GAIN, DATA_MIN);
    add_write(REG_DERIV_GAIN, DATA_MAX);
    add_write(REG_INTEG_GAIN, DATA_MIN);
    add_write(REG_WINDUP_GAIN, DATA_MAX);
    add_write(REG_DRIVE_LOW, 32'hFFFF_0000);
    add_write(REG_DRIVE_HIGH, 32'h0001_0000);
    add_write(REG_STEP_TIME, '0);
    repeat (3) begin
      add_sample(DATA_MIN, DATA_MAX, DATA_MAX, DATA_MAX, DATA_MIN, 1'b0);
    end

    // Random settings, each followed by loop-like traffic and noise
    for (int ph = 0; ph < PHASES; ph++) begin
      add_write(REG_PROP_GAIN, rand_gain());
      add_write(REG_DERIV_GAIN, rand_gain());
      add_write(REG_INTEG_GAIN, rand_gain());
      add_write(REG_WINDUP_GAIN, rand_gain());
      case ($urandom_range(0, 3))
        0: begin
          add_write(REG_DRIVE_LOW, DATA_MIN);
          add_write(REG_DRIVE_HIGH, DATA_MAX);
        end
        1: begin
          lim = $urandom_range(1, 32'h00C8_0000);
          add_write(REG_DRIVE_LOW, -lim);
          add_write(REG_DRIVE_HIGH, lim);
        end
        2: begin
          add_write(REG_DRIVE_LOW, $urandom());
          add_write(REG_DRIVE_HIGH, $urandom());
        end
        default: begin
          lo_w = rand_small(32'h0010_0000);
          add_write(REG_DRIVE_LOW, lo_w);
          add_write(REG_DRIVE_HIGH, lo_w);
        end
      endcase
      case ($urandom_range(0, 3))
        0: add_write(REG_STEP_TIME, '0);
        1: add_write(REG_STEP_TIME, 32'h0000_FFFF);
        2: add_write(REG_STEP_TIME, $urandom_range(0, 65535));
        default: add_write(REG_STEP_TIME, 32'd66);
      endcase
      add_write(REG_BYPASS_MODE, ($urandom_range(0, 5) == 0) ? 32'h1 : 32'h0);
      drain_at = $urandom_range(5, PHASE_WORDS - 5);
      for (int k = 0; k < PHASE_WORDS; k++) begin
        // Hold off once per setting until every result is back
        if (k == drain_at) begin
          pending_q.push_back(drain_mark);
        end
        if ($urandom_range(0, 1) == 1) begin
          t = rand_small(32'h0040_0000);
          add_sample(t, rand_small(32'h0002_0000), rand_small(32'h0008_0000),
                     t + rand_small(32'h0001_0000), rand_small(32'h0002_0000),
                     $urandom_range(0, 15) == 0);
        end else begin
          add_sample(rand_word(), rand_word(), rand_word(), rand_word(), rand_word(),
                     $urandom_range(0, 15) == 0);
        end
      end
    end

    repeat (12) @(posedge clk);
    rst <= 1'b0;

    // Wait for the queue to empty and every result to come back
    while (pending_q.size() != 0 || in_valid || cfg_valid || drive_expect_q.size() != 0) begin
      @(posedge clk);
    end
    repeat (TAIL) @(posedge clk);
    mismatch_cnt = mismatch_cnt + drive_expect_q.size();

    $display("covered %0d samples (%0d open loop, %0d with clear), %0d clamped drives",
             samples_sent, bypass_sent, clears_sent, clamp_hits);
    $display("%0d register writes, %0d results checked, %0d mismatches",
             writes_done, results_checked, mismatch_cnt);
    if (mismatch_cnt == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule
